// ===== hw/rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 to UCS-4 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CpWidth    = 31;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned RemWidth   = 3;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  // Command codes of an input transaction.
  typedef enum logic {
    CmdData = 1'b0,
    CmdEos  = 1'b1
  } cmd_e;

  // Continuation byte tag: 10xxxxxx.
  localparam logic [1:0] ContTag = 2'b10;

  typedef struct packed {
    cmd_e                  command;
    logic [ByteWidth-1:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               error;
    logic               last;
  } result_t;

  // Up to two results caused by one input transaction.
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } res_pair_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Per-byte decode logic plus the sequence state (remaining count, partial).
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_decode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire utf8d_pkg::item_t    item_i,
  output utf8d_pkg::res_pair_t     res_o,
  output logic [utf8d_pkg::RemWidth-1:0] rem_o
);

  typedef struct packed {
    logic                             emit;
    logic                             err;
    logic [utf8d_pkg::CpWidth-1:0]    cp;
    logic [utf8d_pkg::RemWidth-1:0]   rem;
    logic [utf8d_pkg::CpWidth-1:0]    pv;
  } lead_t;

  logic [utf8d_pkg::RemWidth-1:0] rem_q, rem_d;
  logic [utf8d_pkg::CpWidth-1:0]  pv_q, pv_d;

  function automatic lead_t decode_lead(input logic [utf8d_pkg::ByteWidth-1:0] c);
    lead_t l;
    l = '0;
    priority if (c >= 8'hFE) begin
      l.emit = 1'b1;
      l.err  = 1'b1;
    end else if (c >= 8'hFC) begin
      l.pv  = {c[0], 30'd0};
      l.rem = 3'd5;
    end else if (c >= 8'hF8) begin
      l.pv  = {5'd0, c[1:0], 24'd0};
      l.rem = 3'd4;
    end else if (c >= 8'hF0) begin
      l.pv  = {10'd0, c[2:0], 18'd0};
      l.rem = 3'd3;
    end else if (c >= 8'hE0) begin
      l.pv  = {15'd0, c[3:0], 12'd0};
      l.rem = 3'd2;
    end else if (c >= 8'hC0) begin
      l.pv  = {20'd0, c[4:0], 6'd0};
      l.rem = 3'd1;
    end else if (c[7]) begin
      l.emit = 1'b1;
      l.err  = 1'b1;
    end else begin
      l.emit = 1'b1;
      l.cp   = {23'd0, c};
    end
    return l;
  endfunction

  logic                           idle;
  logic                           is_cont;
  lead_t                          lead;
  logic [utf8d_pkg::CpWidth-1:0]  cont_bits;
  logic [utf8d_pkg::CpWidth-1:0]  merged;
  utf8d_pkg::result_t             r_err, r_lead;

  assign idle    = (rem_q == 3'd0) || (rem_q > 3'd5);
  assign is_cont = (item_i.data_byte[7:6] == utf8d_pkg::ContTag);
  assign lead    = decode_lead(item_i.data_byte);

  always_comb begin
    unique case (rem_q)
      3'd5:    cont_bits = {1'b0, item_i.data_byte[5:0], 24'd0};
      3'd4:    cont_bits = {7'd0, item_i.data_byte[5:0], 18'd0};
      3'd3:    cont_bits = {13'd0, item_i.data_byte[5:0], 12'd0};
      3'd2:    cont_bits = {19'd0, item_i.data_byte[5:0], 6'd0};
      default: cont_bits = {25'd0, item_i.data_byte[5:0]};
    endcase
  end

  assign merged = pv_q | cont_bits;

  always_comb begin
    r_err  = '0;
    r_err.error = 1'b1;
    r_lead = '0;
    r_lead.error      = lead.err;
    r_lead.code_point = lead.err ? '0 : lead.cp;
  end

  always_comb begin
    res_o = '0;
    rem_d = rem_q;
    pv_d  = pv_q;
    if (item_i.command == utf8d_pkg::CmdEos) begin
      rem_d = '0;
      pv_d  = '0;
      if (!idle) begin
        res_o.num  = 2'd1;
        res_o.res0 = r_err;
      end
    end else if (idle) begin
      rem_d = lead.rem;
      pv_d  = lead.pv;
      if (lead.emit) begin
        res_o.num  = 2'd1;
        res_o.res0 = r_lead;
      end
    end else if (is_cont) begin
      rem_d = rem_q - 3'd1;
      pv_d  = merged;
      if (rem_q == 3'd1) begin
        pv_d  = '0;
        res_o.num = 2'd1;
        res_o.res0.code_point = merged;
      end
    end else begin
      // Broken sequence: flag it, then restart on this byte as a lead.
      rem_d      = lead.rem;
      pv_d       = lead.pv;
      res_o.res0 = r_err;
      if (lead.emit) begin
        res_o.num  = 2'd2;
        res_o.res1 = r_lead;
      end else begin
        res_o.num  = 2'd1;
      end
    end
    if (res_o.num == 2'd2) begin
      res_o.res1.last = 1'b1;
    end else begin
      res_o.res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pv_q  <= '0;
    end else if (adv_i) begin
      rem_q <= rem_d;
      pv_q  <= pv_d;
    end
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8d_res_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8d_res_fifo
// Small result queue: takes up to two results a cycle, delivers one.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_res_fifo (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  wire utf8d_pkg::res_pair_t            pair_i,
  input  wire logic                            pop_i,
  output utf8d_pkg::result_t                   head_o,
  output logic [utf8d_pkg::FifoCntW-1:0]       cnt_o
);

  utf8d_pkg::result_t                 mem_q [utf8d_pkg::FifoDepth];
  logic [utf8d_pkg::FifoPtrW-1:0]     wr_q, rd_q, wr_d, rd_d, wr_nxt;
  logic [utf8d_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic [1:0]                         n_push;

  assign n_push = push_i ? pair_i.num : 2'd0;
  assign wr_nxt = wr_q + utf8d_pkg::FifoPtrW'(1);

  always_comb begin
    wr_d  = wr_q + utf8d_pkg::FifoPtrW'(n_push);
    rd_d  = rd_q + utf8d_pkg::FifoPtrW'(pop_i);
    cnt_d = cnt_q + utf8d_pkg::FifoCntW'(n_push) - utf8d_pkg::FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= pair_i.res0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_nxt] <= pair_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o = mem_q[rd_q];
  assign cnt_o  = cnt_q;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_to_ucs4_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs4_stream_decoder
// Streams UTF-8 bytes (lead bytes for 1 to 6 byte forms) into 31-bit code
// points, with error results for malformed input and for an end of stream inside a sequence.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  in      | input     | in_valid_i/in_stall_o | item_t: command, data_byte
//  out     | output    | out_valid_o/out_stall_i | result_t: code_point,
//          |           |                      |   error, last
//
// One byte transaction is taken per cycle while in_stall_o is low; the first result
// passes through the input register, then the result queue.
// A broken sequence followed by a lead that emits yields two results; the
// out channel drains one per cycle while out_stall_i is low, so such bytes cost an extra out transfer.
// The input register advances only while the four-entry result queue has
// room for two results; otherwise in_stall_o rises and the byte is held.
// Reset clears the sequence state and the queue; no clearing pass follows.
//
`default_nettype none

module utf8_to_ucs4_stream_decoder (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire utf8d_pkg::item_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output utf8d_pkg::result_t   out_data_o
);

  // Input register.
  logic                   in_vld_q;
  utf8d_pkg::item_t       in_item_q;
  logic                   adv;
  logic                   load;

  utf8d_pkg::res_pair_t   pair;
  logic [utf8d_pkg::RemWidth-1:0] rem;
  logic [utf8d_pkg::FifoCntW-1:0] cnt;
  logic                   pop;

  // Decode the held byte only when the queue can take a full pair.
  assign adv  = in_vld_q && (cnt <= utf8d_pkg::FifoCntW'(utf8d_pkg::FifoDepth - 2));
  assign load = !in_vld_q || adv;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (load) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  utf8d_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_item_q),
    .res_o  (pair),
    .rem_o  (rem)
  );

  // Pop the head whenever the out side takes a transaction.
  assign pop = out_valid_o && !out_stall_i;

  utf8d_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv),
    .pair_i (pair),
    .pop_i  (pop),
    .head_o (out_data_o),
    .cnt_o  (cnt)
  );

  assign out_valid_o = (cnt != '0);

  // Queue never overflows.
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= utf8d_pkg::FifoCntW'(utf8d_pkg::FifoDepth))
    else $error("result queue overflow");

  // Error results carry a zero code point.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.code_point == '0)
    else $error("error result with nonzero code point");

  // Sequence count stays within the six byte form.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem <= 3'd5)
    else $error("remaining count out of range");

  // Without a push or a pop the queue count holds.
  a_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv && !pop |=> cnt == $past(cnt))
    else $error("queue count changed without push or pop");

endmodule

`default_nettype wire
